### sv/twdot_pkg.sv
`default_nettype none
package twdot_pkg;

  // Rows carried on the ports and rows actually accumulated
  localparam int IO_ROWS        = 4;
  localparam int ROWS_PER_TILE  = 4;
  localparam int BLOCK_ELEMENTS = 128;

  // Four 2-bit codes per packed byte, one activation per code
  localparam int LANES   = 4;
  localparam int CODE_W  = 2;
  localparam int WBYTE_W = LANES * CODE_W;
  localparam int ACT_W   = 8;

  // Lane partial: 3 * -128 * 4 = -1536 needs 12 bits signed
  localparam int PSUM_W = 12;
  localparam int ACC_W  = 32;

  typedef logic [WBYTE_W-1:0]          wbyte_t;
  typedef logic [LANES-1:0][ACT_W-1:0] act_vec_t;
  typedef logic signed [PSUM_W-1:0]    psum_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

endpackage
`default_nettype wire

### sv/twdot_in_if.sv
`default_nettype none
interface twdot_in_if;
  logic                               valid;
  logic                               ready;
  logic        [twdot_pkg::WBYTE_W-1:0] weight_row0;
  logic        [twdot_pkg::WBYTE_W-1:0] weight_row1;
  logic        [twdot_pkg::WBYTE_W-1:0] weight_row2;
  logic        [twdot_pkg::WBYTE_W-1:0] weight_row3;
  logic signed [twdot_pkg::ACT_W-1:0]   act_0;
  logic signed [twdot_pkg::ACT_W-1:0]   act_1;
  logic signed [twdot_pkg::ACT_W-1:0]   act_2;
  logic signed [twdot_pkg::ACT_W-1:0]   act_3;
  logic                               last;

  modport source (
    output valid, weight_row0, weight_row1, weight_row2, weight_row3,
           act_0, act_1, act_2, act_3, last,
    input  ready
  );
  modport sink (
    input  valid, weight_row0, weight_row1, weight_row2, weight_row3,
           act_0, act_1, act_2, act_3, last,
    output ready
  );
endinterface
`default_nettype wire

### sv/twdot_out_if.sv
`default_nettype none
interface twdot_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [twdot_pkg::ACC_W-1:0] sum_row0;
  logic signed [twdot_pkg::ACC_W-1:0] sum_row1;
  logic signed [twdot_pkg::ACC_W-1:0] sum_row2;
  logic signed [twdot_pkg::ACC_W-1:0] sum_row3;

  modport source (
    output valid, sum_row0, sum_row1, sum_row2, sum_row3,
    input  ready
  );
  modport sink (
    input  valid, sum_row0, sum_row1, sum_row2, sum_row3,
    output ready
  );
endinterface
`default_nettype wire

### sv/twdot_row_mac.sv
`default_nettype none
module twdot_row_mac (
  input  wire twdot_pkg::wbyte_t   weight,
  input  wire twdot_pkg::act_vec_t acts,
  output twdot_pkg::psum_t         psum
);

  // Bits 7:6 pair with lane 0, bits 1:0 with lane 3; code 3 is a plain times three
  always_comb begin
    twdot_pkg::psum_t code_s;
    twdot_pkg::psum_t act_s;
    twdot_pkg::psum_t total;
    total = '0;
    for (int j = 0; j < twdot_pkg::LANES; j++) begin
      code_s = twdot_pkg::PSUM_W'({1'b0,
               weight[twdot_pkg::CODE_W*(twdot_pkg::LANES-1-j) +: twdot_pkg::CODE_W]});
      act_s  = twdot_pkg::PSUM_W'(signed'(acts[j]));
      total  = total + code_s * act_s;
    end
    psum = total;
  end

endmodule
`default_nettype wire

### sv/ternary_weight_int8_dot_tile.sv
`default_nettype none
// Channel   Role    Payload                                         Transfers when
// in_ch     sink    weight_row0..3, act_0..3, last                  valid && ready
// out_ch    source  sum_row0..3                                     valid && ready
//
// One transaction per cycle in while in_ch.ready is high: input register, then the
// row MACs and 32-bit accumulate feed the result register, which captures the sum
// as the last item leaves the input register. Items without last never wait on the output side.
// A last item stalls in the input register only while a result is held unread.
// Synchronous reset clears valids and accumulators.
module ternary_weight_int8_dot_tile (
  input  wire            clk,
  input  wire            rst_n,
  twdot_in_if.sink       in_ch,
  twdot_out_if.source    out_ch
);

  localparam int ROWS = twdot_pkg::IO_ROWS;

  logic                    s1_valid_r;
  logic                    s1_last_r;
  twdot_pkg::wbyte_t       s1_weight_r [ROWS];
  twdot_pkg::act_vec_t     s1_act_r;

  twdot_pkg::acc_t         acc_r   [ROWS];
  twdot_pkg::acc_t         acc_nxt [ROWS];

  logic                    out_valid_r;
  twdot_pkg::acc_t         out_sum_r [ROWS];

  logic                    out_free;
  logic                    s1_adv;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_last_r      <= in_ch.last;
      s1_weight_r[0] <= in_ch.weight_row0;
      s1_weight_r[1] <= in_ch.weight_row1;
      s1_weight_r[2] <= in_ch.weight_row2;
      s1_weight_r[3] <= in_ch.weight_row3;
      s1_act_r       <= {in_ch.act_3, in_ch.act_2, in_ch.act_1, in_ch.act_0};
    end
  end

  // Row MACs and accumulators; rows past the tile stay at zero
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    if (r < twdot_pkg::ROWS_PER_TILE) begin : g_on
      twdot_pkg::psum_t psum;

      twdot_row_mac u_mac (
        .weight (s1_weight_r[r]),
        .acts   (s1_act_r),
        .psum   (psum)
      );

      assign acc_nxt[r] = acc_r[r] + twdot_pkg::ACC_W'(psum);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          acc_r[r] <= '0;
        end else if (s1_adv) begin
          acc_r[r] <= s1_last_r ? '0 : acc_nxt[r];
        end
      end
    end else begin : g_off
      assign acc_nxt[r] = '0;
      always_ff @(posedge clk) begin
        acc_r[r] <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      for (int r = 0; r < ROWS; r++) begin
        out_sum_r[r] <= acc_nxt[r];
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.sum_row0 = out_sum_r[0];
  assign out_ch.sum_row1 = out_sum_r[1];
  assign out_ch.sum_row2 = out_sum_r[2];
  assign out_ch.sum_row3 = out_sum_r[3];

  // A blocked last item must hold in the input register
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !out_free) |=> (s1_valid_r && s1_last_r))
    else $error("last item dropped while result register full");

  // Accumulators restart from zero once a last item leaves the input register
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (acc_r[0] == '0))
    else $error("accumulator not cleared after last item");

  // A new result only comes from a last item leaving the input register
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last item");

endmodule
`default_nettype wire

### verif/ternary_weight_int8_dot_tile_tb.sv
`timescale 1ns / 1ps
module ternary_weight_int8_dot_tile_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_ITEMS  = 100;
  localparam int PAUSE_AT     = 400;

  typedef struct {
    twdot_pkg::wbyte_t                  weight [twdot_pkg::IO_ROWS];
    logic signed [twdot_pkg::ACT_W-1:0] act    [twdot_pkg::LANES];
    logic                               last;
  } dot_item_t;

  typedef struct {
    twdot_pkg::acc_t sum [twdot_pkg::IO_ROWS];
  } row_sums_t;

  class dot_scoreboard;
    twdot_pkg::acc_t row_acc [twdot_pkg::IO_ROWS];
    row_sums_t       pending_sums [$];
    int              errors;
    int              items_seen;
    int              results_seen;

    function new();
      foreach (row_acc[r]) row_acc[r] = '0;
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
    endfunction

    // Accumulate code * activation per row; on last, queue the sums and clear
    function void note_item(dot_item_t it);
      int        code;
      int        a;
      row_sums_t s;
      items_seen++;
      for (int r = 0; r < twdot_pkg::IO_ROWS; r++) begin
        if (r < twdot_pkg::ROWS_PER_TILE) begin
          for (int j = 0; j < twdot_pkg::LANES; j++) begin
            code = int'(it.weight[r][twdot_pkg::WBYTE_W-1-twdot_pkg::CODE_W*j -:
                                     twdot_pkg::CODE_W]);
            a = int'(it.act[j]);
            row_acc[r] = row_acc[r] + twdot_pkg::acc_t'(code * a);
          end
        end
      end
      if (it.last) begin
        for (int r = 0; r < twdot_pkg::IO_ROWS; r++)
          s.sum[r] = (r < twdot_pkg::ROWS_PER_TILE) ? row_acc[r] : '0;
        pending_sums.push_back(s);
        foreach (row_acc[r]) row_acc[r] = '0;
      end
    endfunction

    function void check_sums(row_sums_t got);
      row_sums_t want;
      if (pending_sums.size() == 0) begin
        $error("unexpected result transaction: no dot product pending");
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      results_seen++;
      for (int r = 0; r < twdot_pkg::IO_ROWS; r++) begin
        if (got.sum[r] !== want.sum[r]) begin
          $error("sum_row%0d mismatch: expected %0d, actual %0d", r, want.sum[r], got.sum[r]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  twdot_in_if  in_ch ();
  twdot_out_if out_ch ();

  ternary_weight_int8_dot_tile dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dot_scoreboard tile_sb = new();

  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int stall_left     = 0;
  int stalls_seen    = 0;
  bit quiet_mode     = 1'b0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts; stall density is redrawn among 0, 20 and 50 percent
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet_mode && $urandom_range(99) < sink_stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(4);
      stalls_seen  <= stalls_seen + 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
    if (cycle_count % 300 == 0) begin
      case ($urandom_range(2))
        0: sink_stall_pct <= 0;
        1: sink_stall_pct <= 20;
        default: sink_stall_pct <= 50;
      endcase
    end
  end

  // Watch both channels; inputs first so a same-edge result finds its expectation
  always @(posedge clk) begin
    dot_item_t seen;
    row_sums_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.weight[0] = in_ch.weight_row0;
        seen.weight[1] = in_ch.weight_row1;
        seen.weight[2] = in_ch.weight_row2;
        seen.weight[3] = in_ch.weight_row3;
        seen.act[0]    = in_ch.act_0;
        seen.act[1]    = in_ch.act_1;
        seen.act[2]    = in_ch.act_2;
        seen.act[3]    = in_ch.act_3;
        seen.last      = in_ch.last;
        tile_sb.note_item(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.sum[0] = out_ch.sum_row0;
        got.sum[1] = out_ch.sum_row1;
        got.sum[2] = out_ch.sum_row2;
        got.sum[3] = out_ch.sum_row3;
        tile_sb.check_sums(got);
      end
    end
  end

  // Weights packed {row0,row1,row2,row3}, activations packed {act_0..act_3}
  function automatic dot_item_t make_item(logic [31:0] weights, logic [31:0] acts, bit last);
    dot_item_t it;
    for (int r = 0; r < twdot_pkg::IO_ROWS; r++) it.weight[r] = weights[31-8*r -: 8];
    for (int j = 0; j < twdot_pkg::LANES; j++) it.act[j] = acts[31-8*j -: 8];
    it.last = last;
    return it;
  endfunction

  function automatic dot_item_t random_item(bit last);
    dot_item_t it;
    for (int r = 0; r < twdot_pkg::IO_ROWS; r++) begin
      case ($urandom_range(9))
        0: it.weight[r] = 8'h00;
        1: it.weight[r] = 8'hFF;
        2: it.weight[r] = ($urandom_range(1) != 0) ? 8'h55 : 8'hAA;
        default: it.weight[r] = twdot_pkg::wbyte_t'($urandom);
      endcase
    end
    for (int j = 0; j < twdot_pkg::LANES; j++) begin
      case ($urandom_range(9))
        0: it.act[j] = -8'sd128;
        1: it.act[j] = 8'sd127;
        2: it.act[j] = 8'sd0;
        3: it.act[j] = -8'sd1;
        default: it.act[j] = twdot_pkg::ACT_W'($urandom);
      endcase
    end
    it.last = last;
    return it;
  endfunction

  // Hold valid high across back-to-back items; drop it only for an idle burst
  task automatic send_item(input dot_item_t it);
    if (!quiet_mode && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.weight_row0 <= it.weight[0];
    in_ch.weight_row1 <= it.weight[1];
    in_ch.weight_row2 <= it.weight[2];
    in_ch.weight_row3 <= it.weight[3];
    in_ch.act_0       <= it.act[0];
    in_ch.act_1       <= it.act[1];
    in_ch.act_2       <= it.act[2];
    in_ch.act_3       <= it.act[3];
    in_ch.last        <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tile_sb.pending_sums.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  sent;
    int  len;
    bit  noise;
    bit  paused;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.weight_row0 <= '0;
    in_ch.weight_row1 <= '0;
    in_ch.weight_row2 <= '0;
    in_ch.weight_row3 <= '0;
    in_ch.act_0       <= '0;
    in_ch.act_1       <= '0;
    in_ch.act_2       <= '0;
    in_ch.act_3       <= '0;
    in_ch.last        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero, code 3 against both activation extremes, codes 1 and 2,
    // lane isolation, and multi-item accumulation before last
    send_idle_pct = 20;
    send_item(make_item(32'h0000_0000, 32'h0000_0000, 1'b1));
    send_item(make_item(32'hFFFF_FFFF, 32'h8080_8080, 1'b1));
    send_item(make_item(32'hFFFF_FFFF, 32'h7F7F_7F7F, 1'b1));
    send_item(make_item(32'h5555_5555, 32'h01FF_807F, 1'b1));
    send_item(make_item(32'hAAAA_AAAA, 32'h7F80_FF01, 1'b1));
    send_item(make_item(32'hC030_0C03, 32'h1122_3344, 1'b1));
    send_item(make_item(32'h030C_30C0, 32'h807F_FF01, 1'b1));
    repeat (4) send_item(make_item(32'hFFFF_FFFF, 32'h8080_8080, 1'b0));
    send_item(make_item(32'hFFFF_FFFF, 32'h8080_8080, 1'b1));
    send_item(make_item(32'h1BE4_00FF, 32'h05FB_807F, 1'b0));
    send_item(make_item(32'hE41B_FF00, 32'h7F80_FB05, 1'b0));
    send_item(make_item(32'h0000_0000, 32'h7F7F_7F7F, 1'b1));
    wait_for_results();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      quiet_mode = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
      case ($urandom_range(2))
        0: send_idle_pct = 0;
        1: send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      noise = ($urandom_range(9) == 0);
      if (noise)
        len = $urandom_range(6, 1);
      else if ($urandom_range(19) == 0)
        len = $urandom_range(40, 9);
      else
        len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        if (noise)
          send_item(random_item(1'($urandom_range(1))));
        else
          send_item(random_item(i == len - 1));
        sent++;
      end
      if (!paused && sent >= PAUSE_AT) begin
        wait_for_results();
        paused = 1'b1;
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tile_sb.pending_sums.size() != 0) begin
      $error("%0d dot-product results never arrived", tile_sb.pending_sums.size());
      tile_sb.errors++;
    end
    $display("Run covered %0d input transactions and %0d checked row-sum results,",
             tile_sb.items_seen, tile_sb.results_seen);
    $display("with %0d result-side stall bursts and one full drain mid-run.", stalls_seen);
    if (tile_sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### ternary_weight_int8_dot_tile.f
sv/twdot_pkg.sv
sv/twdot_in_if.sv
sv/twdot_out_if.sv
sv/twdot_row_mac.sv
sv/ternary_weight_int8_dot_tile.sv
verif/ternary_weight_int8_dot_tile_tb.sv
